/* design/tsps_pkg.sv */
`default_nettype none

package tsps_pkg;

  // Per-slot process state codes.
  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_RUNNABLE = 2'd2,
    ST_RUNNING  = 2'd3
  } slot_status_t;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_EXIT  = 2'd2,
    CMD_FORK  = 2'd3
  } cmd_t;

  localparam int SLEEP_W = 16;
  localparam int SLICE_W = 8;
  localparam int SLOT_OUT_W = 3;
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
  localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 8'd16;

  // One process table entry as stored in the slot memory.
  typedef struct packed {
    slot_status_t        status;
    logic [SLEEP_W-1:0]  sleep_left;
    logic [SLICE_W-1:0]  slice_used;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PRE_RD,
    S_PRE_WR,
    S_WALK_RD,
    S_WALK_WR,
    S_DECIDE,
    S_SW_NEXT,
    S_SW_CUR,
    S_FORK_RD,
    S_FORK_WR,
    S_FINISH
  } seq_state_t;

  // Source of a slot memory write.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_PRE,
    WR_WALK,
    WR_NEXT,
    WR_CUR,
    WR_FORK
  } wr_sel_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic    ready;
    logic    rd_en;
    logic    rd_cur;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    finish;
  } seq_ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic ticks_zero;
    logic idx_last;
    logic do_switch;
    logic fork_hit;
    logic out_free;
  } seq_stat_t;

endpackage

`default_nettype wire

/* design/tsps_if.sv */
`default_nettype none

// Command channel: one item per tick or system call.
interface tsps_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] sleep_ticks;

  modport source (output valid, cmd, sleep_ticks, input ready);
  modport sink (input valid, cmd, sleep_ticks, output ready);
endinterface

// Result channel: one item per command.
interface tsps_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] running_slot;
  logic       switched;
  logic       fork_ok;
  logic [2:0] child_slot;
  logic       sleep_rejected;

  modport source (output valid, running_slot, switched, fork_ok, child_slot, sleep_rejected,
                  input ready);
  modport sink (input valid, running_slot, switched, fork_ok, child_slot, sleep_rejected,
                output ready);
endinterface

`default_nettype wire

/* design/tsps_ram.sv */
`default_nettype none

module tsps_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/tsps_slot_unit.sv */
`default_nettype none

module tsps_slot_unit (
  input  tsps_pkg::slot_entry_t       ent,
  input  logic                        is_cur,
  input  logic [tsps_pkg::SLICE_W-1:0] limit,
  output tsps_pkg::slot_entry_t       upd,
  output logic                        resched
);
  import tsps_pkg::*;

  // Sleep countdown of one slot, then the slice update of the current slot.
  always_comb begin
    upd = ent;
    resched = 1'b0;
    if (ent.status == ST_BLOCKED) begin
      upd.sleep_left = ent.sleep_left - SLEEP_W'(1);
      if (upd.sleep_left == '0) begin
        upd.status = ST_RUNNABLE;
      end
    end
    if (is_cur) begin
      if (upd.status != ST_RUNNING) begin
        resched = 1'b1;
      end else begin
        if (ent.slice_used != SLICE_MAX) begin
          upd.slice_used = ent.slice_used + SLICE_W'(1);
        end
        resched = (upd.slice_used >= limit);
      end
    end
  end

endmodule

`default_nettype wire

/* design/tsps_ctrl.sv */
`default_nettype none

module tsps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  tsps_pkg::seq_stat_t stat,
  output tsps_pkg::seq_ctl_t  ctl
);
  import tsps_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (stat.in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_TICK:  state_next = S_WALK_RD;
          CMD_SLEEP: state_next = stat.ticks_zero ? S_FINISH : S_PRE_RD;
          CMD_EXIT:  state_next = S_PRE_RD;
          CMD_FORK:  state_next = S_FORK_RD;
          default:   state_next = S_FINISH;
        endcase
      end
      S_PRE_RD:  state_next = S_PRE_WR;
      S_PRE_WR:  state_next = S_WALK_RD;
      S_WALK_RD: state_next = S_WALK_WR;
      S_WALK_WR: state_next = stat.idx_last ? S_DECIDE : S_WALK_RD;
      S_DECIDE:  state_next = stat.do_switch ? S_SW_NEXT : S_FINISH;
      S_SW_NEXT: state_next = S_SW_CUR;
      S_SW_CUR:  state_next = S_FINISH;
      S_FORK_RD: state_next = S_FORK_WR;
      S_FORK_WR: begin
        state_next = (stat.fork_hit || stat.idx_last) ? S_FINISH : S_FORK_RD;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl.ready = 1'b0;
    ctl.rd_en = 1'b0;
    ctl.rd_cur = 1'b0;
    ctl.wr_sel = WR_NONE;
    ctl.idx_inc = 1'b0;
    ctl.finish = 1'b0;
    unique case (state)
      S_IDLE:    ctl.ready = 1'b1;
      S_PRE_RD: begin
        ctl.rd_en = 1'b1;
        ctl.rd_cur = 1'b1;
      end
      S_PRE_WR:  ctl.wr_sel = WR_PRE;
      S_WALK_RD: ctl.rd_en = 1'b1;
      S_WALK_WR: begin
        ctl.wr_sel = WR_WALK;
        ctl.idx_inc = !stat.idx_last;
      end
      S_SW_NEXT: ctl.wr_sel = WR_NEXT;
      S_SW_CUR:  ctl.wr_sel = WR_CUR;
      S_FORK_RD: ctl.rd_en = 1'b1;
      S_FORK_WR: begin
        ctl.wr_sel = WR_FORK;
        ctl.idx_inc = !stat.idx_last && !stat.fork_hit;
      end
      S_FINISH:  ctl.finish = stat.out_free;
      default: begin
        ctl.ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/tick_sleep_process_scheduler.sv */
// A tick walks the slot memory, one read and one write per slot, then decides on a switch;
// a switch adds a write to the next slot and one to the current slot. Sleep and exit first
// read and write the current slot, then walk as a tick does. A fork walks from slot 0 and
// claims the first dead slot; a sleep of zero ticks is rejected without a walk. A new item
// is taken only once the last result is in the result register, where it waits until taken.
// Reset (synchronous) clears control state, the slot valid bits and the slice limit.
`default_nettype none

module tick_sleep_process_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tsps_pkg::SLICE_W-1:0]  cfg_wdata,
  tsps_cmd_if.sink                      call,
  tsps_res_if.source                    result
);
  import tsps_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int EXT_W = SLOT_W + SLOT_OUT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  seq_ctl_t  ctl;
  seq_stat_t stat;

  logic [SLICE_W-1:0] slice_limit;
  logic [SLOT_W-1:0]  cur;
  logic [SLOT_W-1:0]  idx;
  cmd_t               cmd_q;
  logic [SLEEP_W-1:0] ticks_q;
  logic               found;
  logic [SLOT_W-1:0]  cand_idx;
  slot_entry_t        cand;
  slot_entry_t        cur_ent;
  logic               resched_q;
  logic               sw_q;
  logic               fork_ok_q;
  logic [SLOT_W-1:0]  child_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic [SLOT_W-1:0]  rd_addr_q;

  logic               accept;
  logic [SLOT_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t        eff;
  slot_entry_t        dflt;
  slot_entry_t        upd;
  logic               unit_resched;
  logic               ram_we;
  logic [SLOT_W-1:0]  wr_addr;
  slot_entry_t        wr_data;
  logic               fork_hit;
  logic [EXT_W-1:0]   cur_ext;
  logic [EXT_W-1:0]   child_ext;

  assign accept = call.valid && ctl.ready;
  assign call.ready = ctl.ready;

  // Slice limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_limit <= SLICE_LIMIT_RST;
    end else if (cfg_we) begin
      slice_limit <= cfg_wdata;
    end
  end

  // Slot memory read side; an entry never written reads as its reset value.
  assign rd_addr = ctl.rd_cur ? cur : idx;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    dflt.status = (rd_addr_q == '0) ? ST_RUNNING : ST_DEAD;
    dflt.sleep_left = '0;
    dflt.slice_used = '0;
    eff = valid_q[rd_addr_q] ? slot_entry_t'(ram_rdata) : dflt;
  end

  assign fork_hit = (eff.status == ST_DEAD);

  tsps_slot_unit u_unit (
    .ent     (eff),
    .is_cur  (idx == cur),
    .limit   (slice_limit),
    .upd     (upd),
    .resched (unit_resched)
  );

  // Slot memory write side.
  always_comb begin
    wr_addr = idx;
    wr_data = upd;
    ram_we = 1'b0;
    unique case (ctl.wr_sel)
      WR_NONE: ram_we = 1'b0;
      WR_PRE: begin
        ram_we = 1'b1;
        wr_addr = cur;
        wr_data = eff;
        if (cmd_q == CMD_SLEEP) begin
          wr_data.status = ST_BLOCKED;
          wr_data.sleep_left = ticks_q;
        end else begin
          wr_data.status = ST_DEAD;
        end
      end
      WR_WALK: ram_we = 1'b1;
      WR_NEXT: begin
        ram_we = 1'b1;
        wr_addr = cand_idx;
        wr_data = cand;
        wr_data.status = ST_RUNNING;
      end
      WR_CUR: begin
        ram_we = 1'b1;
        wr_addr = cur;
        wr_data = cur_ent;
        wr_data.slice_used = '0;
        if (cur_ent.status == ST_RUNNING) begin
          wr_data.status = ST_RUNNABLE;
        end
      end
      WR_FORK: begin
        ram_we = fork_hit;
        wr_data.status = ST_RUNNABLE;
        wr_data.sleep_left = '0;
        wr_data.slice_used = '0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  tsps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Valid bits: set on the first write of each slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Current slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (ctl.wr_sel == WR_CUR) begin
      cur <= cand_idx;
    end
  end

  // Item capture, walk index and per-item flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      found <= 1'b0;
      resched_q <= 1'b0;
      sw_q <= 1'b0;
      fork_ok_q <= 1'b0;
      child_q <= '0;
    end else if (accept) begin
      idx <= '0;
      found <= 1'b0;
      resched_q <= 1'b0;
      sw_q <= 1'b0;
      fork_ok_q <= 1'b0;
      child_q <= '0;
    end else begin
      if (ctl.idx_inc) begin
        idx <= idx + SLOT_W'(1);
      end
      if (ctl.wr_sel == WR_WALK && idx != '0 && !found && upd.status == ST_RUNNABLE) begin
        found <= 1'b1;
      end
      if (ctl.wr_sel == WR_WALK && idx == cur) begin
        resched_q <= unit_resched;
      end
      if (ctl.wr_sel == WR_CUR) begin
        sw_q <= 1'b1;
      end
      if (ctl.wr_sel == WR_FORK && fork_hit) begin
        fork_ok_q <= 1'b1;
        child_q <= idx;
      end
    end
  end

  // Item payload and walk captures.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(call.cmd);
      ticks_q <= call.sleep_ticks;
    end
    if (ctl.wr_sel == WR_WALK) begin
      if (idx == '0) begin
        cand <= upd;
        cand_idx <= '0;
      end else if (!found && upd.status == ST_RUNNABLE) begin
        cand <= upd;
        cand_idx <= idx;
      end
      if (idx == cur) begin
        cur_ent <= upd;
      end
    end
  end

  // Sequencer.
  assign stat.in_valid = call.valid;
  assign stat.cmd = cmd_q;
  assign stat.ticks_zero = (ticks_q == '0);
  assign stat.idx_last = (idx == LAST_SLOT);
  assign stat.do_switch = resched_q && (cand_idx != cur);
  assign stat.fork_hit = fork_hit;
  assign stat.out_free = !result.valid || result.ready;

  tsps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Result register.
  assign cur_ext = EXT_W'(cur);
  assign child_ext = EXT_W'(child_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.running_slot <= cur_ext[SLOT_OUT_W-1:0];
      result.switched <= sw_q;
      result.fork_ok <= fork_ok_q;
      result.child_slot <= child_ext[SLOT_OUT_W-1:0];
      result.sleep_rejected <= (cmd_q == CMD_SLEEP) && (ticks_q == '0);
    end
  end

  // A switch always moves the current slot somewhere else.
  a_switch_moves: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_sel == WR_CUR) |=> (cur != $past(cur)))
    else $error("switch left the current slot unchanged");

  // A fork claim is recorded only from a dead slot seen during the fork walk.
  a_fork_source: assert property (@(posedge clk) disable iff (rst)
    $rose(fork_ok_q) |-> $past(ctl.wr_sel == WR_FORK && fork_hit))
    else $error("fork flag set outside a fork claim");

  // A fork never reschedules and never rejects a sleep.
  a_fork_exclusive: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.fork_ok) |-> (!result.switched && !result.sleep_rejected))
    else $error("fork result carries switch or reject flags");

  // A rejected sleep leaves the current slot where it was.
  a_reject_no_switch: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.sleep_rejected) |-> !result.switched)
    else $error("rejected sleep changed the current slot");

endmodule

`default_nettype wire
